FILE: design/aes_pkg.sv
// AES-128 package: types, S-box tables and round helper functions.
package aes_pkg;

  localparam int unsigned KeyWidth   = 128;
  localparam int unsigned HalfWidth  = 64;
  localparam int unsigned RoundCount = 10;
  localparam int unsigned CfgAddrW   = 1;

  // register indexes
  localparam logic [CfgAddrW-1:0] RegKeyHi = 1'b0;
  localparam logic [CfgAddrW-1:0] RegKeyLo = 1'b1;

  // direction codes
  localparam logic DirEnc = 1'b0;
  localparam logic DirDec = 1'b1;

  typedef logic [127:0] block_t;

  // one pipeline slot: state, direction, valid
  typedef struct packed {
    logic   vld;
    logic   dir;
    block_t st;
  } slot_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // table of the forward S-box
  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  // table of the inverse S-box
  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

  // byte i of a block, byte 0 at the top
  function automatic logic [7:0] byte_of(input block_t b, input int i);
    byte_of = b[127-8*i -: 8];
  endfunction

  // key schedule step: next round key from the current one and rcon
  function automatic block_t next_rk(input block_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    next_rk = {w0, w1, w2, w3};
  endfunction

  function automatic logic [31:0] mix_fwd(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    mix_fwd = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
               a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
               a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
               xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
  endfunction

  // inverse mix: pre-multiply by {05,00,04,00} pattern, then forward mix
  function automatic logic [31:0] mix_inv(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, u, v;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    u = xt(xt(a0 ^ a2));
    v = xt(xt(a1 ^ a3));
    mix_inv = mix_fwd({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
  endfunction

  // one round on a block; dir selects forward or inverse; do_mix low skips mix
  function automatic block_t round_f(input block_t s, input logic dir,
                                     input logic do_mix);
    block_t t, m;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (dir == DirEnc)
          t[127-8*(r+4*c) -: 8] = SBOX[byte_of(s, r + 4*((c + r) & 3))];
        else
          t[127-8*(r+4*c) -: 8] = ISBOX[byte_of(s, r + 4*((c + 3*r) & 3))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[127-32*c -: 32] = (dir == DirEnc) ? mix_fwd(t[127-32*c -: 32])
                                          : mix_inv(t[127-32*c -: 32]);
    end
    round_f = do_mix ? m : t;
  endfunction

endpackage

FILE: design/aes128_block_cipher.sv
// Top level of the pipelined AES-128 cipher.
// One block can enter per cycle while in_stall is low. Each block passes
// through an input register with the initial key add, then ten round
// stages, one per round, each ending in a register. A stall on the result
// side holds every stage and the input. After reset and after any key write
// the input stalls while the new round keys ripple through the key schedule
// registers. The user must write the key only while no block is in flight;
// the block itself does not enforce it.
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo
);

  aes_pkg::block_t rk [11];
  aes_pkg::slot_t  sl [11];
  aes_pkg::slot_t  s0_r;
  logic            hold;
  logic            ks_busy;

  aes_keysched u_ks (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .busy(ks_busy), .rk(rk)
  );

  // whole pipe holds while the output is stalled and full
  assign hold     = out_stall && sl[10].vld;
  assign in_stall = hold || ks_busy;

  // entry stage: initial key add
  always_ff @(posedge clk) begin
    if (!rst_n) s0_r.vld <= 1'b0;
    else if (!hold) s0_r.vld <= in_valid && !ks_busy;
    if (!hold) begin
      s0_r.dir <= in_req_type;
      s0_r.st  <= {in_block_hi, in_block_lo} ^
                  ((in_req_type == aes_pkg::DirEnc) ? rk[0] : rk[10]);
    end
  end
  assign sl[0] = s0_r;

  for (genvar i = 1; i < 11; i++) begin : g_round
    aes_round #(.Round(i)) u_round (
      .clk(clk), .rst_n(rst_n), .hold(hold), .slot_i(sl[i-1]),
      .rk_enc(rk[i]), .rk_dec(rk[10-i]), .slot_o(sl[i])
    );
  end

  assign out_valid     = sl[10].vld;
  assign out_result_hi = sl[10].st[127:64];
  assign out_result_lo = sl[10].st[63:0];

endmodule

FILE: design/aes_keysched.sv
// Round key store: expands the configured key into all eleven round keys.
module aes_keysched (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_addr,
  input  logic [63:0]         cfg_wdata,
  output logic                busy,
  output aes_pkg::block_t     rk [11]
);

  logic [127:0] key_r;
  logic [127:0] key_nxt;
  logic [7:0]   rc [10];
  logic [3:0]   settle_r;
  logic [3:0]   settle_nxt;

  // key register writes
  always_comb begin
    key_nxt = key_r;
    if (cfg_we && cfg_addr == aes_pkg::RegKeyHi) key_nxt[127:64] = cfg_wdata;
    if (cfg_we && cfg_addr == aes_pkg::RegKeyLo) key_nxt[63:0]   = cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_r <= '0;
    else        key_r <= key_nxt;
  end

  // settle count: loaded with the number of chain registers after reset or a key write, then counts down to zero
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) settle_nxt = 4'(aes_pkg::RoundCount);
    else if (settle_r != 4'd0) settle_nxt = settle_r - 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) settle_r <= 4'(aes_pkg::RoundCount);
    else        settle_r <= settle_nxt;
  end

  assign busy = cfg_we || (settle_r != 4'd0);

  // round key chain; registered so the stage paths stay short
  assign rc[0] = 8'h01;
  for (genvar i = 1; i < 10; i++) begin : g_rc
    assign rc[i] = aes_pkg::xt(rc[i-1]);
  end

  assign rk[0] = key_r;
  for (genvar i = 1; i < 11; i++) begin : g_rk
    aes_pkg::block_t rk_r;
    always_ff @(posedge clk) begin
      if (!rst_n) rk_r <= '0;
      else        rk_r <= aes_pkg::next_rk(rk[i-1], rc[i-1]);
    end
    assign rk[i] = rk_r;
  end

endmodule

FILE: design/aes_round.sv
// One pipeline stage: a cipher round plus the key add, with stall hold.
module aes_round #(
  parameter int unsigned Round = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            hold,
  input  aes_pkg::slot_t  slot_i,
  input  aes_pkg::block_t rk_enc,
  input  aes_pkg::block_t rk_dec,
  output aes_pkg::slot_t  slot_o
);

  aes_pkg::slot_t slot_r, slot_nxt;
  aes_pkg::block_t rs;

  // decrypt adds the key before inverse mix, so mix-by-key is folded in
  always_comb begin
    if (slot_i.dir == aes_pkg::DirEnc) begin
      rs = aes_pkg::round_f(slot_i.st, aes_pkg::DirEnc, Round != aes_pkg::RoundCount)
           ^ rk_enc;
    end else begin
      rs = aes_pkg::round_f(slot_i.st, aes_pkg::DirDec, 1'b0) ^ rk_dec;
      if (Round != aes_pkg::RoundCount) begin
        for (int c = 0; c < 4; c++) rs[127-32*c -: 32] = aes_pkg::mix_inv(rs[127-32*c -: 32]);
      end
    end
    slot_nxt.vld = slot_i.vld;
    slot_nxt.dir = slot_i.dir;
    slot_nxt.st  = rs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) slot_r.vld <= 1'b0;
    else if (!hold) slot_r.vld <= slot_nxt.vld;
    if (!hold) begin
      slot_r.dir <= slot_nxt.dir;
      slot_r.st  <= slot_nxt.st;
    end
  end

  assign slot_o = slot_r;

endmodule
